@@ rtl/barometric_sensor_compensation_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the barometric sensor compensation block
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef BAROMETRIC_SENSOR_COMPENSATION_MACROS_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_MACROS_SVH
`ifndef ASSERT_OFF
// Checks that cons holds in every cycle in which ante holds.
`define BSC_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
// Checks that expr holds in every cycle out of reset.
`define BSC_ASSERT_ALWAYS(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("invariant check failed");
`else
`define BSC_ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define BSC_ASSERT_ALWAYS(name, clk, rst_n, expr)
`endif
`endif

@@ rtl/bsc_pkg.sv @@
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types, widths, register indexes and reset values of the
// barometric sensor compensation block.
// ----------------------------------------------------------------------------
`default_nettype none

package bsc_pkg;

  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = $clog2(NUM_REGS);
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [REG_IDX_W-1:0] REG_TEMP_COEFF_1   = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_TEMP_COEFF_2   = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_TEMP_COEFF_3   = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_PRESS_COEFF_1  = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_PRESS_COEFF_23 = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_PRESS_COEFF_45 = REG_IDX_W'(5);
  localparam logic [REG_IDX_W-1:0] REG_PRESS_COEFF_67 = REG_IDX_W'(6);
  localparam logic [REG_IDX_W-1:0] REG_PRESS_COEFF_89 = REG_IDX_W'(7);

  localparam logic [CFG_DATA_W-1:0] REG_RESET [NUM_REGS] = '{
    32'd27504, 32'd26435, 32'h0000FC18, 32'd36477,
    32'd198235715, 32'd9177895, 32'd1015873529, 32'd393266936
  };
  localparam logic [CFG_DATA_W-1:0] REG_MASK [NUM_REGS] = '{
    32'h0000FFFF, 32'h0000FFFF, 32'h0000FFFF, 32'h0000FFFF,
    32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF
  };

  // Divider operand widths: numerator magnitude, divisor magnitude, quotient.
  localparam int UN_W  = 57;
  localparam int UW_W  = 36;
  localparam int Q_W   = 39;
  localparam int P16_W = Q_W + 1;

  typedef struct packed {
    logic [19:0] adc_temperature;
    logic [19:0] adc_pressure;
  } bsc_in_t;

  typedef struct packed {
    logic signed [20:0] fine_temperature;
    logic signed [15:0] temperature_centi_c;
    logic [24:0]        pressure_q8_pa;
    logic               pressure_invalid;
  } bsc_out_t;

  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0]        p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } coeff_t;

  typedef struct packed {
    logic signed [20:0] tf;
    logic signed [15:0] cc;
  } temp_t;

  typedef struct packed {
    temp_t       temp;
    logic [19:0] adc_p;
  } temp_res_t;

  typedef struct packed {
    temp_t           temp;
    logic [UN_W-1:0] un;
    logic [UW_W-1:0] uw;
    logic            neg;
    logic            invalid;
  } div_in_t;

  typedef struct packed {
    temp_t                   temp;
    logic signed [P16_W-1:0] p16;
    logic                    invalid;
  } div_out_t;

endpackage

`default_nettype wire

@@ rtl/bsc_stream_if.sv @@
// ----------------------------------------------------------------------------
// bsc_in_if / bsc_out_if
// Valid/ready channels carrying raw readings in and compensated results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsc_in_if;
  import bsc_pkg::*;
  logic    valid;
  logic    ready;
  bsc_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bsc_out_if;
  import bsc_pkg::*;
  logic     valid;
  logic     ready;
  bsc_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/bsc_temp_pipe.sv @@
// ----------------------------------------------------------------------------
// bsc_temp_pipe
// Seven-stage temperature polynomial: fine temperature and centi-degrees.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_temp_pipe (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  bsc_pkg::bsc_in_t   in_data,
  input  bsc_pkg::coeff_t    coeff,
  output logic               out_vld,
  output bsc_pkg::temp_res_t out_data
);
  import bsc_pkg::*;

  localparam int LAT = 7;

  logic [LAT-1:0]     vld_r;
  logic [19:0]        adcp_r [LAT];

  logic signed [20:0] d_r, d_nxt;
  logic signed [36:0] dt2_r, dt2_nxt, dt2b_r;
  logic signed [41:0] dd_full;
  logic [40:0]        dd_r;
  logic signed [57:0] ddt3_r, ddt3_nxt;
  logic signed [58:0] num_r, num_nxt;
  logic [58:0]        num_abs;
  logic [57:0]        mag_r;
  logic               neg5_r, neg6_r;
  logic [60:0]        mag5;
  logic [23:0]        tfm_r;
  logic [18:0]        ccm_r;
  logic [24:0]        tf_ext, tf_s;
  logic [19:0]        cc_ext, cc_s;
  temp_t              temp_r, temp_nxt;

  assign d_nxt    = $signed({1'b0, in_data.adc_temperature}) - $signed({1'b0, coeff.t1, 4'b0});
  assign dt2_nxt  = $signed(d_r) * $signed(coeff.t2);
  assign dd_full  = $signed(d_r) * $signed(d_r);
  assign ddt3_nxt = $signed({1'b0, dd_r}) * $signed(coeff.t3);
  assign num_nxt  = $signed({{2{dt2b_r[36]}}, dt2b_r, 20'b0}) + $signed({ddt3_r[57], ddt3_r});
  assign num_abs  = num_r[58] ? -num_r : num_r;
  assign mag5     = {1'b0, mag_r, 2'b0} + {3'b0, mag_r};

  // Restore the sign and clamp to the output ranges.
  always_comb begin
    tf_ext = {1'b0, tfm_r};
    cc_ext = {1'b0, ccm_r};
    tf_s   = neg6_r ? -tf_ext : tf_ext;
    cc_s   = neg6_r ? -cc_ext : cc_ext;
    if ($signed(tf_s) > 25'sd1048575) begin
      temp_nxt.tf = 21'sd1048575;
    end else if ($signed(tf_s) < -25'sd1048576) begin
      temp_nxt.tf = -21'sd1048576;
    end else begin
      temp_nxt.tf = tf_s[20:0];
    end
    if ($signed(cc_s) > 20'sd20479) begin
      temp_nxt.cc = 16'sd20479;
    end else if ($signed(cc_s) < -20'sd20480) begin
      temp_nxt.cc = -16'sd20480;
    end else begin
      temp_nxt.cc = cc_s[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      adcp_r[0] <= in_data.adc_pressure;
      for (int k = 1; k < LAT; k++) begin
        adcp_r[k] <= adcp_r[k-1];
      end
      d_r    <= d_nxt;
      dt2_r  <= dt2_nxt;
      dd_r   <= dd_full[40:0];
      dt2b_r <= dt2_r;
      ddt3_r <= ddt3_nxt;
      num_r  <= num_nxt;
      mag_r  <= num_abs[57:0];
      neg5_r <= num_r[58];
      tfm_r  <= mag_r[57:34];
      ccm_r  <= mag5[60:42];
      neg6_r <= neg5_r;
      temp_r <= temp_nxt;
    end
  end

  assign out_vld        = vld_r[LAT-1];
  assign out_data.temp  = temp_r;
  assign out_data.adc_p = adcp_r[LAT-1];

endmodule

`default_nettype wire

@@ rtl/bsc_press_front.sv @@
// ----------------------------------------------------------------------------
// bsc_press_front
// Seven-stage pressure front end: numerator and divisor of the pressure
// quotient, reduced to magnitudes with sign and zero-divisor flags.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_press_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  bsc_pkg::temp_res_t in_data,
  input  bsc_pkg::coeff_t    coeff,
  output logic               out_vld,
  output bsc_pkg::div_in_t   out_data
);
  import bsc_pkg::*;

  localparam int LAT     = 7;
  localparam int ADCP_ST = 4;

  logic [LAT-1:0]     vld_r;
  temp_t              temp_r [LAT-1];
  logic [19:0]        adcp_r [ADCP_ST];

  logic signed [21:0] v_r, v_nxt;
  logic signed [43:0] vv_full;
  logic [40:0]        vv_r;
  logic signed [37:0] vp5_r, vp5_nxt, vp2_r, vp2_nxt, vp5b_r, vp2b_r;
  logic signed [57:0] vvp6_r, vvp6_nxt, vvp3_r, vvp3_nxt;
  logic signed [58:0] v2_r, v2_nxt, b_r, b_nxt;
  logic [20:0]        pdiff;
  logic signed [59:0] x_full, w_full;
  logic signed [44:0] x16_r;
  logic signed [35:0] w16_r, w16b_r;
  logic signed [58:0] n_r, n_nxt;
  logic [58:0]        n_abs;
  logic [35:0]        w_abs;
  div_in_t            res_r, res_nxt;

  assign v_nxt    = $signed({in_data.temp.tf[20], in_data.temp.tf}) - 22'sd128000;
  assign vv_full  = v_r * v_r;
  assign vp5_nxt  = v_r * $signed(coeff.p5);
  assign vp2_nxt  = v_r * $signed(coeff.p2);
  assign vvp6_nxt = $signed({1'b0, vv_r}) * $signed(coeff.p6);
  assign vvp3_nxt = $signed({1'b0, vv_r}) * $signed(coeff.p3);

  // var2 and the divisor polynomial, both exact.
  assign v2_nxt = $signed({vvp6_r[57], vvp6_r}) + $signed({{4{vp5b_r[37]}}, vp5b_r, 17'b0})
                + $signed({{8{coeff.p4[15]}}, coeff.p4, 35'b0});
  assign b_nxt  = $signed({3'b000, 1'b1, 55'b0}) + $signed({vvp3_r[57], vvp3_r})
                + $signed({vp2b_r[37], vp2b_r, 20'b0});

  assign pdiff  = 21'h100000 - {1'b0, adcp_r[ADCP_ST-1]};
  assign x_full = $signed({8'b0, pdiff, 31'b0}) - $signed({v2_r[58], v2_r});
  assign w_full = $signed({1'b0, coeff.p1}) * $signed(b_r[58:16]);
  assign n_nxt  = x16_r * 59'sd6250;

  always_comb begin
    n_abs            = n_r[58] ? -n_r : n_r;
    w_abs            = w16b_r[35] ? -w16b_r : w16b_r;
    res_nxt.temp     = temp_r[LAT-2];
    res_nxt.un       = n_abs[UN_W-1:0];
    res_nxt.uw       = w_abs;
    res_nxt.neg      = n_r[58] ^ w16b_r[35];
    res_nxt.invalid  = (w16b_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      temp_r[0] <= in_data.temp;
      for (int k = 1; k < LAT-1; k++) begin
        temp_r[k] <= temp_r[k-1];
      end
      adcp_r[0] <= in_data.adc_p;
      for (int k = 1; k < ADCP_ST; k++) begin
        adcp_r[k] <= adcp_r[k-1];
      end
      v_r    <= v_nxt;
      vv_r   <= vv_full[40:0];
      vp5_r  <= vp5_nxt;
      vp2_r  <= vp2_nxt;
      vvp6_r <= vvp6_nxt;
      vvp3_r <= vvp3_nxt;
      vp5b_r <= vp5_r;
      vp2b_r <= vp2_r;
      v2_r   <= v2_nxt;
      b_r    <= b_nxt;
      x16_r  <= x_full[59:15];
      w16_r  <= w_full[58:23];
      n_r    <= n_nxt;
      w16b_r <= w16_r;
      res_r  <= res_nxt;
    end
  end

  assign out_vld  = vld_r[LAT-1];
  assign out_data = res_r;

endmodule

`default_nettype wire

@@ rtl/bsc_divider.sv @@
// ----------------------------------------------------------------------------
// bsc_divider
// Pipelined restoring divider: one quotient bit per stage, an overflow test
// up front and sign and saturation applied after the last bit.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  bsc_pkg::div_in_t  in_data,
  output logic              out_vld,
  output bsc_pkg::div_out_t out_data
);
  import bsc_pkg::*;

  localparam int LOW_W = UN_W - (Q_W - 16);

  // Index 0 is the setup stage, index k+1 holds the result of quotient step k.
  // The remainder and divisor are not needed after the last step.
  logic [Q_W+1:0]    vld_r;
  logic [UW_W-1:0]   rem_r  [Q_W];
  logic [Q_W-1:0]    quo_r  [Q_W+1];
  logic [UW_W-1:0]   uw_r   [Q_W];
  logic              ovf_r  [Q_W+1];
  logic              neg_r  [Q_W+1];
  logic              inv_r  [Q_W+1];
  temp_t             temp_r [Q_W+1];

  logic [LOW_W-1:0]  hi_part;
  logic              ovf_nxt;
  logic [Q_W-1:0]    pm;
  logic [P16_W-1:0]  pm_ext;
  div_out_t          res_r, res_nxt;

  // The scaled quotient reaches 2^39 exactly when the high numerator bits
  // already reach the divisor.
  assign hi_part = in_data.un[UN_W-1:Q_W-16];
  assign ovf_nxt = ({{(UW_W-LOW_W){1'b0}}, hi_part} >= in_data.uw);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Q_W:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= {{(UW_W-LOW_W){1'b0}}, hi_part};
      quo_r[0]  <= {in_data.un[Q_W-17:0], 16'b0};
      uw_r[0]   <= in_data.uw;
      ovf_r[0]  <= ovf_nxt;
      neg_r[0]  <= in_data.neg;
      inv_r[0]  <= in_data.invalid;
      temp_r[0] <= in_data.temp;
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [UW_W-1:0] rem2;
    logic            ge;

    // Numerator bits leave the top of quo_r while quotient bits enter below.
    assign rem2 = {rem_r[k][UW_W-2:0], quo_r[k][Q_W-1]};
    assign ge   = (rem2 >= uw_r[k]);

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[k+1]  <= {quo_r[k][Q_W-2:0], ge};
        ovf_r[k+1]  <= ovf_r[k];
        neg_r[k+1]  <= neg_r[k];
        inv_r[k+1]  <= inv_r[k];
        temp_r[k+1] <= temp_r[k];
      end
    end

    if (k < Q_W-1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1] <= ge ? rem2 - uw_r[k] : rem2;
          uw_r[k+1]  <= uw_r[k];
        end
      end
    end
  end

  always_comb begin
    pm               = ovf_r[Q_W] ? {Q_W{1'b1}} : quo_r[Q_W];
    pm_ext           = {1'b0, pm};
    res_nxt.temp     = temp_r[Q_W];
    res_nxt.p16      = neg_r[Q_W] ? -pm_ext : pm_ext;
    res_nxt.invalid  = inv_r[Q_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign out_vld  = vld_r[Q_W+1];
  assign out_data = res_r;

endmodule

`default_nettype wire

@@ rtl/bsc_press_back.sv @@
// ----------------------------------------------------------------------------
// bsc_press_back
// Five-stage second-order pressure correction, saturation and result format.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_press_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  bsc_pkg::div_out_t in_data,
  input  bsc_pkg::coeff_t   coeff,
  output logic              out_vld,
  output bsc_pkg::bsc_out_t out_data
);
  import bsc_pkg::*;

  localparam int LAT    = 5;
  localparam int P16_ST = 3;

  logic [LAT-1:0]          vld_r;
  temp_t                   temp_r [LAT-1];
  logic                    inv_r  [LAT-1];
  logic signed [P16_W-1:0] p16_r  [P16_ST];

  logic signed [31:0]      s;
  logic signed [63:0]      sqr_full, sqp9_nxt;
  logic [62:0]             sqr_r;
  logic signed [55:0]      p8_nxt, p8_r, p8b_r;
  logic signed [63:0]      sqp9_r;
  logic signed [49:0]      c_r, c_nxt;
  logic signed [46:0]      f16_r, f16_nxt;
  logic signed [38:0]      pq;
  bsc_out_t                res_r, res_nxt;

  assign s        = in_data.p16[P16_W-1:8];
  assign sqr_full = s * s;
  assign p8_nxt   = in_data.p16 * $signed(coeff.p8);
  assign sqp9_nxt = $signed({1'b0, sqr_r[62:16]}) * $signed(coeff.p9);
  assign c_nxt    = $signed({sqp9_r[63], sqp9_r[63:15]})
                  + $signed({{9{p8b_r[55]}}, p8b_r[55:15]})
                  + $signed({{18{coeff.p7[15]}}, coeff.p7, 16'b0});
  assign f16_nxt  = $signed({{7{p16_r[P16_ST-1][P16_W-1]}}, p16_r[P16_ST-1]})
                  + $signed({c_r[49], c_r[49:4]});
  assign pq       = f16_r[46:8];

  always_comb begin
    res_nxt.fine_temperature    = temp_r[LAT-2].tf;
    res_nxt.temperature_centi_c = temp_r[LAT-2].cc;
    res_nxt.pressure_invalid    = inv_r[LAT-2];
    if (inv_r[LAT-2] || pq[38]) begin
      res_nxt.pressure_q8_pa = '0;
    end else if (|pq[37:25]) begin
      res_nxt.pressure_q8_pa = '1;
    end else begin
      res_nxt.pressure_q8_pa = pq[24:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      temp_r[0] <= in_data.temp;
      inv_r[0]  <= in_data.invalid;
      for (int k = 1; k < LAT-1; k++) begin
        temp_r[k] <= temp_r[k-1];
        inv_r[k]  <= inv_r[k-1];
      end
      p16_r[0] <= in_data.p16;
      for (int k = 1; k < P16_ST; k++) begin
        p16_r[k] <= p16_r[k-1];
      end
      sqr_r  <= sqr_full[62:0];
      p8_r   <= p8_nxt;
      sqp9_r <= sqp9_nxt;
      p8b_r  <= p8_r;
      c_r    <= c_nxt;
      f16_r  <= f16_nxt;
      res_r  <= res_nxt;
    end
  end

  assign out_vld  = vld_r[LAT-1];
  assign out_data = res_r;

endmodule

`default_nettype wire

@@ rtl/barometric_sensor_compensation.sv @@
// ----------------------------------------------------------------------------
// Barometric sensor compensation
// Takes one raw temperature/pressure reading pair per transaction and returns
// fine temperature, temperature in 0.01 degC and pressure in 1/256 Pa, with a
// flag when the pressure divisor is zero. The datapath is a 60-stage
// pipeline followed by a two-entry output buffer: one transaction is taken
// every cycle while the output buffer is not full. Most of the depth is the
// restoring divider, one quotient bit per stage. Calibration registers must
// be written through the cfg port only while no transaction is in flight; the
// block does not enforce this. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "barometric_sensor_compensation_macros.svh"

module barometric_sensor_compensation (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  bsc_in_if.sink                         in_stream,
  bsc_out_if.source                      out_stream
);
  import bsc_pkg::*;

  typedef enum logic [2:0] {
    BUF_EMPTY = 3'b001,
    BUF_ONE   = 3'b010,
    BUF_FULL  = 3'b100
  } buf_state_t;

  logic [CFG_DATA_W-1:0] cfg_r [NUM_REGS];
  logic [REG_IDX_W-1:0]  widx;
  coeff_t                coeff;

  logic                  en;
  logic                  temp_vld, front_vld, div_vld, back_vld;
  temp_res_t             temp_res;
  div_in_t               div_in;
  div_out_t              div_out;
  bsc_out_t              back_data;

  buf_state_t            buf_r, buf_nxt;
  bsc_out_t              head_r, head_nxt, skid_r, skid_nxt;
  logic                  push, pop;

  // Calibration registers.
  assign widx = cfg_index[REG_IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_r[i] <= REG_RESET[i];
      end
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      cfg_r[widx] <= cfg_wdata & REG_MASK[widx];
    end
  end

  assign coeff.t1 = cfg_r[REG_TEMP_COEFF_1][15:0];
  assign coeff.t2 = cfg_r[REG_TEMP_COEFF_2][15:0];
  assign coeff.t3 = cfg_r[REG_TEMP_COEFF_3][15:0];
  assign coeff.p1 = cfg_r[REG_PRESS_COEFF_1][15:0];
  assign coeff.p2 = cfg_r[REG_PRESS_COEFF_23][15:0];
  assign coeff.p3 = cfg_r[REG_PRESS_COEFF_23][31:16];
  assign coeff.p4 = cfg_r[REG_PRESS_COEFF_45][15:0];
  assign coeff.p5 = cfg_r[REG_PRESS_COEFF_45][31:16];
  assign coeff.p6 = cfg_r[REG_PRESS_COEFF_67][15:0];
  assign coeff.p7 = cfg_r[REG_PRESS_COEFF_67][31:16];
  assign coeff.p8 = cfg_r[REG_PRESS_COEFF_89][15:0];
  assign coeff.p9 = cfg_r[REG_PRESS_COEFF_89][31:16];

  // The whole pipeline advances together unless the output buffer is full.
  assign en              = (buf_r != BUF_FULL);
  assign in_stream.ready = en;

  bsc_temp_pipe u_temp (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_stream.valid),
    .in_data  (in_stream.data),
    .coeff    (coeff),
    .out_vld  (temp_vld),
    .out_data (temp_res)
  );

  bsc_press_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (temp_vld),
    .in_data  (temp_res),
    .coeff    (coeff),
    .out_vld  (front_vld),
    .out_data (div_in)
  );

  bsc_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (front_vld),
    .in_data  (div_in),
    .out_vld  (div_vld),
    .out_data (div_out)
  );

  bsc_press_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (div_vld),
    .in_data  (div_out),
    .coeff    (coeff),
    .out_vld  (back_vld),
    .out_data (back_data)
  );

  // Two-entry output buffer: the head drives the port, the skid entry
  // catches the result that leaves the pipeline while the head is stalled.
  assign push = en && back_vld;
  assign pop  = out_stream.valid && out_stream.ready;

  always_comb begin
    buf_nxt  = buf_r;
    head_nxt = head_r;
    skid_nxt = skid_r;
    unique case (buf_r)
      BUF_EMPTY: begin
        if (push) begin
          head_nxt = back_data;
          buf_nxt  = BUF_ONE;
        end
      end
      BUF_ONE: begin
        if (push && pop) begin
          head_nxt = back_data;
        end else if (push) begin
          skid_nxt = back_data;
          buf_nxt  = BUF_FULL;
        end else if (pop) begin
          buf_nxt = BUF_EMPTY;
        end
      end
      BUF_FULL: begin
        if (pop) begin
          head_nxt = skid_r;
          buf_nxt  = BUF_ONE;
        end
      end
      default: begin
        buf_nxt = BUF_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r <= BUF_EMPTY;
    end else begin
      buf_r <= buf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign out_stream.valid = (buf_r == BUF_ONE) || (buf_r == BUF_FULL);
  assign out_stream.data  = head_r;

  `BSC_ASSERT_IMPLY(a_invalid_zero, clk, rst_n, out_stream.valid && out_stream.data.pressure_invalid, out_stream.data.pressure_q8_pa == 25'd0)

  `BSC_ASSERT_IMPLY(a_centi_range, clk, rst_n, out_stream.valid, ($signed(out_stream.data.temperature_centi_c) >= -16'sd20480) && ($signed(out_stream.data.temperature_centi_c) <= 16'sd20479))

  `BSC_ASSERT_IMPLY(a_temp_sign, clk, rst_n, out_stream.valid && (out_stream.data.temperature_centi_c != 16'd0), out_stream.data.temperature_centi_c[15] == out_stream.data.fine_temperature[20])

  `BSC_ASSERT_ALWAYS(a_no_push_when_full, clk, rst_n, !((buf_r == BUF_FULL) && back_vld && en))

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// Barometric sensor compensation testbench
// Streams raw temperature/pressure reading pairs through the block under
// several calibration settings and idle patterns. Every result is compared
// field by field against a fixed-point prediction of the compensation math.
// ----------------------------------------------------------------------------
`default_nettype none

class compensation_scoreboard;
  logic [31:0] coeff_regs [bsc_pkg::NUM_REGS];
  bsc_pkg::bsc_out_t expected_results [$];
  int mismatches;
  bit failed;

  function new();
    for (int i = 0; i < bsc_pkg::NUM_REGS; i++) coeff_regs[i] = bsc_pkg::REG_RESET[i];
    mismatches = 0;
    failed = 0;
  endfunction

  function void set_reg(logic [3:0] idx, logic [31:0] val);
    if (idx < bsc_pkg::NUM_REGS) coeff_regs[idx] = val & bsc_pkg::REG_MASK[idx];
  endfunction

  function longint sx(logic [15:0] bits);
    return longint'($signed(bits));
  endfunction

  function longint clamp(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function bsc_pkg::bsc_out_t compensate(bsc_pkg::bsc_in_t rd);
    bsc_pkg::bsc_out_t res;
    longint at, ap, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    longint d, num, tf, cc, v, v2, x16, b, w16, n, p16, s, sq, c, f16, pq8;
    longint unsigned mag, un, uw, q, r, pm;
    at = longint'(rd.adc_temperature);
    ap = longint'(rd.adc_pressure);
    t1 = longint'(coeff_regs[0][15:0]);
    t2 = sx(coeff_regs[1][15:0]);
    t3 = sx(coeff_regs[2][15:0]);
    p1 = longint'(coeff_regs[3][15:0]);
    p2 = sx(coeff_regs[4][15:0]);
    p3 = sx(coeff_regs[4][31:16]);
    p4 = sx(coeff_regs[5][15:0]);
    p5 = sx(coeff_regs[5][31:16]);
    p6 = sx(coeff_regs[6][15:0]);
    p7 = sx(coeff_regs[6][31:16]);
    p8 = sx(coeff_regs[7][15:0]);
    p9 = sx(coeff_regs[7][31:16]);

    // Temperature: exact numerator, then truncation toward zero.
    d = at - 16 * t1;
    num = d * t2 * (longint'(1) << 20) + d * d * t3;
    mag = num < 0 ? longint'(-num) : num;
    tf = longint'(mag >> 34);
    cc = longint'((mag * 5) >> 42);
    if (num < 0) begin
      tf = -tf;
      cc = -cc;
    end
    tf = clamp(tf, -1048576, 1048575);
    cc = clamp(cc, -20480, 20479);

    // Pressure works from the saturated fine temperature.
    v = tf - 128000;
    v2 = v * v * p6 + v * p5 * (longint'(1) << 17) + p4 * (longint'(1) << 35);
    x16 = ((longint'(1048576) - ap) * (longint'(1) << 31) - v2) >>> 15;
    b = (longint'(1) << 55) + p3 * v * v + p2 * v * (longint'(1) << 20);
    w16 = (p1 * (b >>> 16)) >>> 23;

    res.fine_temperature = tf[20:0];
    res.temperature_centi_c = cc[15:0];
    if (w16 == 0) begin
      res.pressure_q8_pa = '0;
      res.pressure_invalid = 1'b1;
    end else begin
      n = x16 * 6250;
      un = n < 0 ? longint'(-n) : n;
      uw = w16 < 0 ? longint'(-w16) : w16;
      q = un / uw;
      r = un % uw;
      if (q >= (64'd1 << 23)) pm = (64'd1 << 39) - 1;
      else pm = (q << 16) + ((r << 16) / uw);
      p16 = longint'(pm);
      if ((n < 0) != (w16 < 0)) p16 = -p16;
      s = p16 >>> 8;
      sq = longint'(longint'(unsigned'(s * s)) >> 16);
      c = ((sq * p9) >>> 15) + ((p16 * p8) >>> 15) + p7 * 65536;
      f16 = p16 + (c >>> 4);
      pq8 = clamp(f16 >>> 8, 0, 33554431);
      res.pressure_q8_pa = pq8[24:0];
      res.pressure_invalid = 1'b0;
    end
    return res;
  endfunction

  function void note_reading(bsc_pkg::bsc_in_t rd);
    expected_results.push_back(compensate(rd));
  endfunction

  function void check_result(bsc_pkg::bsc_out_t got);
    bsc_pkg::bsc_out_t exp_res;
    if (expected_results.size() == 0) begin
      failed = 1;
      mismatches++;
      if (mismatches <= 10) $display("unexpected result transaction: %p", got);
      return;
    end
    exp_res = expected_results.pop_front();
    if (got.fine_temperature !== exp_res.fine_temperature ||
        got.temperature_centi_c !== exp_res.temperature_centi_c ||
        got.pressure_q8_pa !== exp_res.pressure_q8_pa ||
        got.pressure_invalid !== exp_res.pressure_invalid) begin
      failed = 1;
      mismatches++;
      if (mismatches <= 10) begin
        $display("result mismatch: expected tf=%0d cc=%0d p=%0d inv=%0b",
                 exp_res.fine_temperature, exp_res.temperature_centi_c,
                 exp_res.pressure_q8_pa, exp_res.pressure_invalid);
        $display("                 got      tf=%0d cc=%0d p=%0d inv=%0b",
                 got.fine_temperature, got.temperature_centi_c,
                 got.pressure_q8_pa, got.pressure_invalid);
      end
    end
  endfunction

  function int pending();
    return expected_results.size();
  endfunction
endclass

module tb;
  import bsc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 70;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = CFG_IDX_W'(9);

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int send_idle_pct;
  int recv_stall_pct;
  int cycles = 0;

  bsc_in_if in_if();
  bsc_out_if out_if();
  compensation_scoreboard sb;

  barometric_sensor_compensation u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_stream (in_if),
    .out_stream(out_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("barometric_sensor_compensation verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.data);
  end

  // Caller sits at a clock edge; the enable stays high until the last write.
  task cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task load_calibration(logic [31:0] t1, logic [31:0] t2, logic [31:0] t3,
                        logic [31:0] p1, logic [31:0] p23, logic [31:0] p45,
                        logic [31:0] p67, logic [31:0] p89);
    cfg_write(CFG_IDX_W'(REG_TEMP_COEFF_1), t1);
    cfg_write(CFG_IDX_W'(REG_TEMP_COEFF_2), t2);
    cfg_write(CFG_IDX_W'(REG_TEMP_COEFF_3), t3);
    cfg_write(CFG_IDX_W'(REG_PRESS_COEFF_1), p1);
    cfg_write(CFG_IDX_W'(REG_PRESS_COEFF_23), p23);
    cfg_write(CFG_IDX_W'(REG_PRESS_COEFF_45), p45);
    cfg_write(CFG_IDX_W'(REG_PRESS_COEFF_67), p67);
    cfg_write(CFG_IDX_W'(REG_PRESS_COEFF_89), p89);
    cfg_write(CFG_IDX_UNUSED, $urandom());
    cfg_we <= 1'b0;
  endtask

  task send_reading(logic [19:0] adc_t, logic [19:0] adc_p);
    bsc_in_t rd;
    rd.adc_temperature = adc_t;
    rd.adc_pressure = adc_p;
    in_if.valid <= 1'b1;
    in_if.data <= rd;
    do @(posedge clk); while (!in_if.ready);
    sb.note_reading(rd);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      in_if.data <= 40'({$urandom(), $urandom()});
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task send_directed();
    send_reading(20'h00000, 20'h00000);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'h00000, 20'hFFFFF);
    send_reading(20'hFFFFF, 20'h00000);
    send_reading(20'h80000, 20'h80000);
    send_reading(20'h55555, 20'hAAAAA);
    send_reading(20'hAAAAA, 20'h55555);
    send_reading(20'd519888, 20'd415148);
    send_reading(20'd440064, 20'd300000);
  endtask

  task send_random(int count, bit near_nominal);
    logic [19:0] adc_t, adc_p;
    for (int i = 0; i < count; i++) begin
      if (near_nominal && $urandom_range(1)) begin
        adc_t = 20'($urandom_range(580000, 440000));
        adc_p = 20'($urandom_range(520000, 250000));
      end else begin
        adc_t = 20'($urandom());
        adc_p = 20'($urandom());
      end
      send_reading(adc_t, adc_p);
    end
    in_if.valid <= 1'b0;
  endtask

  task settle();
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task set_idle_mode(int mode);
    send_idle_pct = (mode == 1) ? 47 : (mode == 3) ? 29 : 0;
    recv_stall_pct = (mode == 2) ? 47 : (mode == 3) ? 29 : 0;
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    set_idle_mode(0);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset calibration first.
    send_directed();
    send_random(200, 1);
    settle();

    set_idle_mode(1);
    load_calibration($urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom(), $urandom(), $urandom());
    send_directed();
    send_random(200, 0);
    settle();

    // Largest positive coefficients drive the saturation paths.
    set_idle_mode(2);
    load_calibration(32'hFFFF, 32'h7FFF, 32'h7FFF, 32'hFFFF,
                     32'h7FFF7FFF, 32'h7FFF7FFF, 32'h7FFF7FFF, 32'h7FFF7FFF);
    send_directed();
    send_random(200, 0);
    settle();

    set_idle_mode(3);
    load_calibration(32'h0000, 32'h8000, 32'h8000, 32'h0001,
                     32'h80008000, 32'h80008000, 32'h80008000, 32'h80008000);
    send_directed();
    send_random(200, 0);
    settle();

    // A zero pressure scale forces the divisor to zero on every reading.
    set_idle_mode(0);
    load_calibration(32'd27504, 32'd26435, 32'hFFFFFC18, 32'h0000,
                     $urandom(), $urandom(), $urandom(), $urandom());
    send_directed();
    send_random(100, 1);
    settle();

    set_idle_mode(3);
    load_calibration(REG_RESET[0], REG_RESET[1], REG_RESET[2], REG_RESET[3],
                     REG_RESET[4], REG_RESET[5], REG_RESET[6], REG_RESET[7]);
    send_random(250, 1);
    settle();

    if (!sb.failed && sb.pending() == 0) begin
      $display("barometric_sensor_compensation verification clean");
    end else begin
      $display("barometric_sensor_compensation verification failed");
    end
    $finish;
  end
endmodule

`default_nettype wire

@@ files.f @@
+incdir+rtl
rtl/bsc_pkg.sv
rtl/bsc_stream_if.sv
rtl/bsc_temp_pipe.sv
rtl/bsc_press_front.sv
rtl/bsc_divider.sv
rtl/bsc_press_back.sv
rtl/barometric_sensor_compensation.sv
verif/tb.sv
